// ===== rtl/slrg_pkg.sv =====
// shared types, constants and arithmetic helpers of the shuffled random generator
package slrg_pkg;

	localparam int TableDepth = 32;
	localparam int IDX_W      = $clog2(TableDepth);
	localparam int VAL_W      = 31;
	localparam int LCG_W      = 32;
	localparam int MULT_W     = 15;
	localparam int PROD_W     = VAL_W + MULT_W;
	localparam int CNT_W      = 6;
	localparam int STEP_W     = 4;

	localparam logic [MULT_W-1:0] MULT      = 15'd16807;
	localparam logic [VAL_W-1:0]  MODULUS   = 31'h7FFF_FFFF;
	localparam logic [CNT_W-1:0]  WARM_LAST = 6'd39;

	// program addresses
	localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] ST_DISP  = 4'd1;
	localparam logic [STEP_W-1:0] ST_WINIT = 4'd2;
	localparam logic [STEP_W-1:0] ST_WMUL  = 4'd3;
	localparam logic [STEP_W-1:0] ST_WRED  = 4'd4;
	localparam logic [STEP_W-1:0] ST_WRD0  = 4'd5;
	localparam logic [STEP_W-1:0] ST_WSET  = 4'd6;
	localparam logic [STEP_W-1:0] ST_GMUL  = 4'd7;
	localparam logic [STEP_W-1:0] ST_SWAP  = 4'd8;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_WARM_INIT,
		OP_MUL,
		OP_WARM_STORE,
		OP_READ0,
		OP_WARM_DONE,
		OP_MUL_READ,
		OP_SWAP
	} op_t;

	typedef enum logic [1:0] {
		C_ALWAYS,
		C_NO_GEN,
		C_WARMED,
		C_CNT_MORE
	} cond_t;

	typedef struct packed {
		logic              busy;
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic warmed;
		logic cnt_more;
	} dp_status_t;

	// 16807*v mod (2^31-1) from the full product: fold high part onto low part
	function automatic logic [VAL_W-1:0] mod_reduce(input logic [PROD_W-1:0] prod);
		logic [VAL_W:0] sum;
		sum = {1'b0, prod[VAL_W-1:0]} + (VAL_W+1)'(prod[PROD_W-1:VAL_W]);
		if (sum >= {1'b0, MODULUS}) begin
			sum = sum - {1'b0, MODULUS};
		end
		return sum[VAL_W-1:0];
	endfunction

	// stored lcg value after a seed request
	function automatic logic [LCG_W-1:0] seed_to_lcg(input logic [LCG_W-1:0] seed);
		logic [LCG_W-1:0] mag;
		logic [LCG_W-1:0] neg;
		mag = seed[LCG_W-1] ? (~seed + 1'b1) : seed;
		neg = ~mag + 1'b1;
		if (neg == '0) begin
			neg = '1;
		end
		return neg;
	endfunction

	// starting value of warm-up; zero or negative falls back to one
	function automatic logic [VAL_W-1:0] warm_start(input logic [LCG_W-1:0] lcg);
		logic [LCG_W-1:0] v;
		v = ~lcg + 1'b1;
		if (v == '0 || v[LCG_W-1]) begin
			v = LCG_W'(1);
		end
		return v[VAL_W-1:0];
	endfunction

endpackage

// ===== rtl/slrg_ucode_rom.sv =====
// control program of the generator, one control word per step
module slrg_ucode_rom (
	input  logic [slrg_pkg::STEP_W-1:0] step,
	output slrg_pkg::uword_t            uword
);
	import slrg_pkg::*;

	always_comb begin
		case (step)
			ST_IDLE:  uword = '{busy: 1'b0, op: OP_NONE,       cond: C_NO_GEN,   target: ST_IDLE};
			ST_DISP:  uword = '{busy: 1'b1, op: OP_NONE,       cond: C_WARMED,   target: ST_GMUL};
			ST_WINIT: uword = '{busy: 1'b1, op: OP_WARM_INIT,  cond: C_ALWAYS,   target: ST_WMUL};
			ST_WMUL:  uword = '{busy: 1'b1, op: OP_MUL,        cond: C_ALWAYS,   target: ST_WRED};
			ST_WRED:  uword = '{busy: 1'b1, op: OP_WARM_STORE, cond: C_CNT_MORE, target: ST_WMUL};
			ST_WRD0:  uword = '{busy: 1'b1, op: OP_READ0,      cond: C_ALWAYS,   target: ST_WSET};
			ST_WSET:  uword = '{busy: 1'b1, op: OP_WARM_DONE,  cond: C_ALWAYS,   target: ST_GMUL};
			ST_GMUL:  uword = '{busy: 1'b1, op: OP_MUL_READ,   cond: C_ALWAYS,   target: ST_SWAP};
			ST_SWAP:  uword = '{busy: 1'b1, op: OP_SWAP,       cond: C_ALWAYS,   target: ST_IDLE};
			default:  uword = '{busy: 1'b1, op: OP_NONE,       cond: C_ALWAYS,   target: ST_IDLE};
		endcase
	end

endmodule

// ===== rtl/slrg_sequencer.sv =====
// step counter with conditional jumps driven by the control word
module slrg_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        kind,
	input  slrg_pkg::uword_t            uword,
	input  slrg_pkg::dp_status_t        status,
	output logic [slrg_pkg::STEP_W-1:0] step
);
	import slrg_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              taken;

	always_comb begin
		case (uword.cond)
			C_ALWAYS:   taken = 1'b1;
			C_NO_GEN:   taken = !(start && kind);
			C_WARMED:   taken = status.warmed;
			C_CNT_MORE: taken = status.cnt_more;
			default:    taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= taken ? uword.target : step_q + 1'b1;
		end
	end

	assign step = step_q;

endmodule

// ===== rtl/slrg_datapath.sv =====
// generator registers, modular multiplier and shuffle table
module slrg_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  slrg_pkg::op_t              op,
	input  logic                       seed_req,
	input  logic [slrg_pkg::LCG_W-1:0] seed_value,
	output slrg_pkg::dp_status_t       status,
	output logic                       done,
	output logic [slrg_pkg::VAL_W-1:0] random_value
);
	import slrg_pkg::*;

	logic [LCG_W-1:0]  lcg_q;
	logic [VAL_W-1:0]  last_q;
	logic              warmed_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PROD_W-1:0] prod_q;
	logic [VAL_W-1:0]  rd_q;
	logic [VAL_W-1:0]  tbl_mem [TableDepth];

	logic [VAL_W-1:0] reduced;
	logic [IDX_W-1:0] swap_idx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	assign reduced  = mod_reduce(prod_q);
	// top bits of the last value pick the table slot
	assign swap_idx = last_q[VAL_W-1 -: IDX_W];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = swap_idx;
		rd_en   = 1'b0;
		rd_addr = swap_idx;
		case (op)
			OP_WARM_STORE: begin
				// first eight warm-up steps only advance the generator
				wr_en   = (cnt_q < CNT_W'(TableDepth));
				wr_addr = cnt_q[IDX_W-1:0];
			end
			OP_SWAP:     wr_en = 1'b1;
			OP_READ0: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			OP_MUL_READ: rd_en = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= reduced;
		end
		if (rd_en) begin
			rd_q <= tbl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_MUL || op == OP_MUL_READ) begin
			prod_q <= PROD_W'(MULT) * PROD_W'(lcg_q[VAL_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q    <= '0;
			last_q   <= '0;
			warmed_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (seed_req) begin
				lcg_q    <= seed_to_lcg(seed_value);
				last_q   <= '0;
				warmed_q <= 1'b0;
			end else begin
				case (op)
					OP_WARM_INIT: begin
						lcg_q <= {1'b0, warm_start(lcg_q)};
						cnt_q <= WARM_LAST;
					end
					OP_WARM_STORE: begin
						lcg_q <= {1'b0, reduced};
						cnt_q <= cnt_q - 1'b1;
					end
					OP_WARM_DONE: begin
						last_q   <= rd_q;
						warmed_q <= 1'b1;
					end
					OP_SWAP: begin
						lcg_q  <= {1'b0, reduced};
						last_q <= rd_q;
						done_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign status.warmed   = warmed_q;
	assign status.cnt_more = (cnt_q != '0);
	assign done            = done_q;
	assign random_value    = last_q;

endmodule

// ===== rtl/shuffled_lcg_random_generator.sv =====
// top level of the shuffled minimal-standard random generator
//
// channel   direction  strobe / handshake        payload
// request   in         start high, busy low      kind, seed_value
// result    out        done high for one cycle   random_value
//
// a seed request gives no result
// once warmed up, a generate request does one multiply and one
// fold-and-subtract step per generator advance plus the table read and swap
// the first generate after a seed or reset adds a warm-up of 40 advances
// done rises in the cycle after the last step, when busy is already low again
// reset clears the generator and control state; the result side cannot stall
module shuffled_lcg_random_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            kind,
	input  logic signed [slrg_pkg::LCG_W-1:0] seed_value,
	output logic                            done,
	output logic [slrg_pkg::VAL_W-1:0]      random_value
);
	import slrg_pkg::*;

	logic [STEP_W-1:0] step;
	uword_t            uword;
	dp_status_t        status;
	logic              seed_req;

	assign busy     = uword.busy;
	assign seed_req = start && !uword.busy && !kind;

	slrg_ucode_rom u_rom (
		.step  (step),
		.uword (uword)
	);

	slrg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.uword  (uword),
		.status (status),
		.step   (step)
	);

	slrg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (uword.op),
		.seed_req     (seed_req),
		.seed_value   (seed_value),
		.status       (status),
		.done         (done),
		.random_value (random_value)
	);

endmodule

// ===== tb/tb_shuffled_lcg_random_generator.sv =====
// self-checking testbench of the shuffled minimal-standard random generator
module tb_shuffled_lcg_random_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import slrg_pkg::*;

	localparam logic KIND_SEED = 1'b0;
	localparam logic KIND_GEN  = 1'b1;

	localparam longint LCG_MULT     = 16807;
	localparam longint LCG_MOD      = 2147483647;
	localparam longint SCHRAGE_QUOT = 127773;
	localparam longint SCHRAGE_REM  = 2836;
	localparam int     WARM_STEPS   = 40;
	localparam int     SLOTS        = 32;

	localparam logic [31:0] SEED_ZERO    = 32'h0000_0000;
	localparam logic [31:0] SEED_ONE     = 32'h0000_0001;
	localparam logic [31:0] SEED_MINUS1  = 32'hFFFF_FFFF;
	localparam logic [31:0] SEED_MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] SEED_MOD_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SEED_MOD_NEG = 32'h8000_0001;
	localparam int          REPORT_LIMIT = 10;
	localparam int          TAIL_CYCLES  = 20;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    kind;
	logic signed [LCG_W-1:0] seed_value;
	logic                    done;
	logic [VAL_W-1:0]        random_value;

	// predictor state
	logic [31:0]      gen_state;
	logic [30:0]      prev_output;
	logic [30:0]      shuffle_slots [SLOTS];
	logic             gen_warm;

	logic [30:0]      expected_values [$];
	int               mismatch_count;
	int               seed_count;
	int               gen_count;
	int               values_checked;
	bit               idle_enabled;

	shuffled_lcg_random_generator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.seed_value  (seed_value),
		.done        (done),
		.random_value(random_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// 16807*v mod (2^31-1) by Schrage's decomposition
	function automatic logic [30:0] park_miller_step(input logic [31:0] v);
		longint wide_v;
		longint quot;
		longint rem;
		longint t;
		wide_v = longint'({32'd0, v});
		quot = wide_v / SCHRAGE_QUOT;
		rem = wide_v % SCHRAGE_QUOT;
		t = LCG_MULT * rem - SCHRAGE_REM * quot;
		if (t < 0) begin
			t += LCG_MOD;
		end
		return t[30:0];
	endfunction

	task automatic predict_request(input logic k, input logic [31:0] s,
			output logic has_value, output logic [30:0] value);
		logic [31:0] mag;
		logic [31:0] v;
		logic [4:0]  pick;
		has_value = 1'b0;
		value = '0;
		if (k == KIND_SEED) begin
			mag = s[31] ? (~s + 32'd1) : s;
			gen_state = ~mag + 32'd1;
			if (gen_state == '0) begin
				gen_state = '1;
			end
			prev_output = '0;
			gen_warm = 1'b0;
		end else begin
			if (!gen_warm) begin
				v = ~gen_state + 32'd1;
				if (v == '0 || v[31]) begin
					v = 32'd1;
				end
				// fill the table from the top down, the first eight steps are discarded
				for (int j = WARM_STEPS - 1; j >= 0; j--) begin
					v = {1'b0, park_miller_step(v)};
					if (j < SLOTS) begin
						shuffle_slots[j] = v[30:0];
					end
				end
				gen_state = v;
				prev_output = shuffle_slots[0];
				gen_warm = 1'b1;
			end
			gen_state = {1'b0, park_miller_step(gen_state)};
			pick = prev_output[30:26];
			prev_output = shuffle_slots[pick];
			shuffle_slots[pick] = gen_state[30:0];
			has_value = 1'b1;
			value = prev_output;
		end
	endtask

	task automatic note_mismatch(input string what, input logic [30:0] want,
			input logic [30:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
		end
	endtask

	// one request; returns at the edge that accepts it, start left high
	task automatic send_request(input logic k, input logic [31:0] s);
		logic        has_value;
		logic [30:0] value;
		start <= 1'b1;
		kind <= k;
		seed_value <= s;
		do @(posedge clk); while (busy !== 1'b0);
		predict_request(k, s, has_value, value);
		if (has_value) begin
			expected_values.push_back(value);
		end
		if (k == KIND_SEED) begin
			seed_count++;
		end else begin
			gen_count++;
		end
	endtask

	task automatic sender_gap();
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_values.size() != 0);
	endtask

	function automatic logic [31:0] pick_seed();
		case ($urandom_range(0, 7))
			0: return SEED_ZERO;
			1: return SEED_ONE;
			2: return SEED_MINUS1;
			3: return SEED_MOST_NEG;
			4: return SEED_MOD_POS;
			5: return SEED_MOD_NEG;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		logic [30:0] want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			values_checked++;
			if (expected_values.size() == 0) begin
				note_mismatch("value with no request pending", '0, random_value);
			end else begin
				want = expected_values.pop_front();
				if (random_value !== want) begin
					note_mismatch("random_value", want, random_value);
				end
			end
		end
	end

	// generate right after reset behaves as seed one
	task automatic test_unseeded_start();
		send_request(KIND_GEN, $urandom);
		send_request(KIND_GEN, SEED_MOST_NEG);
	endtask

	task automatic test_seed_special_cases();
		send_request(KIND_SEED, SEED_ZERO);
		send_request(KIND_GEN, SEED_MINUS1);
		send_request(KIND_SEED, SEED_MOST_NEG);
		send_request(KIND_GEN, SEED_ZERO);
		send_request(KIND_GEN, $urandom);
		// seed at the modulus collapses to a stream of zeros
		send_request(KIND_SEED, SEED_MOD_POS);
		send_request(KIND_GEN, $urandom);
		send_request(KIND_GEN, $urandom);
		send_request(KIND_SEED, SEED_MOD_NEG);
		send_request(KIND_GEN, $urandom);
		send_request(KIND_SEED, SEED_ONE);
		send_request(KIND_GEN, $urandom);
		send_request(KIND_GEN, $urandom);
		send_request(KIND_SEED, SEED_MINUS1);
		send_request(KIND_GEN, $urandom);
		// a second seed overrides the first before any warm-up
		send_request(KIND_SEED, 32'd12345);
		send_request(KIND_SEED, 32'h7FFF_FFFE);
		send_request(KIND_GEN, SEED_MOD_POS);
		send_request(KIND_GEN, $urandom);
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int n_requests);
		for (int i = 0; i < n_requests; i++) begin
			sender_gap();
			if ($urandom_range(0, 99) < 6) begin
				send_request(KIND_SEED, pick_seed());
				// occasional reseed before any generate
				if ($urandom_range(0, 4) == 0) begin
					send_request(KIND_SEED, $urandom);
				end
			end else begin
				send_request(KIND_GEN, $urandom);
			end
		end
	endtask

	initial begin
		#10_000_000;
		$display("timeout");
		$display("** shuffled_lcg_random_generator: FAILED **");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= KIND_SEED;
		seed_value <= '0;
		gen_state = '0;
		prev_output = '0;
		gen_warm = 1'b0;
		foreach (shuffle_slots[i]) shuffle_slots[i] = '0;
		mismatch_count = 0;
		seed_count = 0;
		gen_count = 0;
		values_checked = 0;
		idle_enabled = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unseeded_start();
		test_seed_special_cases();
		test_random_traffic(900);
		wait_for_results();
		test_random_traffic(600);
		idle_enabled = 1'b0;
		test_random_traffic(400);

		start <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d seed and %0d generate requests, %0d values checked",
			seed_count, gen_count, values_checked);
		$display("including zero, one, minus one, most negative and modulus seeds");
		if (mismatch_count == 0 && expected_values.size() == 0) begin
			$display("** shuffled_lcg_random_generator: PASSED **");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("** shuffled_lcg_random_generator: FAILED **");
		end
		$finish;
	end

endmodule
